@@ design/fopm_pkg.sv @@
package fopm_pkg;

	// Port widths of the payload fields
	localparam int BASE_W = 64;
	localparam int EXP_W  = 64;
	localparam int MOD_W  = 11;
	localparam int RES_W  = 10;

	// Defaults of the top-level parameters
	localparam int MAX_MODULUS_DEF = 1024;
	localparam int TABLE_DEPTH_DEF = 8192;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_FILL,
		ST_AMOD,
		ST_POWI,
		ST_POW,
		ST_READ,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic fill_step;
		logic amod_step;
		logic pow_init;
		logic mul_step;
		logic rd_en;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic small_mod;
		logic fill_done;
		logic amod_done;
		logic pow_done;
		logic out_free;
	} sts_t;

endpackage

@@ design/fibonacci_of_power_mod_core.sv @@
// Flow: a modulus of 0 or 1 skips straight to the result; otherwise the block fills a residue table
// up to the Pisano period p (at most 6n), reduces a mod p bit-serially, raises it to b mod p by serial
// square-and-multiply, and reads the table entry at that index into the output register.
// Words are taken one at a time; a new word is taken once the previous one is done,
// while its result may still wait in the output register. Fill loop and modmul set the pace.
// Reset: arst_n clears the controller, the output valid and the stored period; no table clear.
module fibonacci_of_power_mod_core #(
	parameter int MAX_MODULUS = fopm_pkg::MAX_MODULUS_DEF,
	parameter int TABLE_DEPTH = fopm_pkg::TABLE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fopm_pkg::BASE_W-1:0] base_value,
	input  logic [fopm_pkg::EXP_W-1:0]  exponent_value,
	input  logic [fopm_pkg::MOD_W-1:0]  modulus_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fopm_pkg::RES_W-1:0]  fib_residue
);
	import fopm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fopm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fopm_dp #(
		.MAX_MODULUS (MAX_MODULUS),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.modulus_value  (modulus_value),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.fib_residue    (fib_residue)
	);

	// A taken word blocks the input on the next cycle
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken twice in a row");

	// Loading a result always shows it on the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result load lost");

	// Table fill never overlaps input acceptance
	a_fill_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step |-> in_stall)
		else $error("input open during table fill");

endmodule

@@ design/fopm_ram.sv @@
module fopm_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/fopm_ctrl.sv @@
module fopm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  fopm_pkg::sts_t  sts,
	output fopm_pkg::cmd_t  cmd
);
	import fopm_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				state_d = sts.small_mod ? ST_DONE : ST_FILL;
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_done) begin
					state_d = ST_AMOD;
				end
			end
			ST_AMOD: begin
				cmd.amod_step = 1'b1;
				if (sts.amod_done) begin
					state_d = ST_POWI;
				end
			end
			ST_POWI: begin
				cmd.pow_init = 1'b1;
				state_d      = ST_POW;
			end
			ST_POW: begin
				cmd.mul_step = 1'b1;
				if (sts.pow_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/fopm_dp.sv @@
module fopm_dp #(
	parameter int MAX_MODULUS = fopm_pkg::MAX_MODULUS_DEF,
	parameter int TABLE_DEPTH = fopm_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fopm_pkg::cmd_t                cmd,
	output fopm_pkg::sts_t                sts,
	input  logic [fopm_pkg::BASE_W-1:0]   base_value,
	input  logic [fopm_pkg::EXP_W-1:0]    exponent_value,
	input  logic [fopm_pkg::MOD_W-1:0]    modulus_value,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [fopm_pkg::RES_W-1:0]    fib_residue
);
	import fopm_pkg::*;

	localparam int RW = $clog2(MAX_MODULUS);
	localparam int MW = RW + 1;
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(IW);
	localparam int BW = $clog2(BASE_W);

	// One step of a serial modular multiply: 2r + (bit ? addend : 0) mod p
	function automatic logic [IW-1:0] mstep(
		input logic [IW-1:0] r,
		input logic [IW-1:0] addend,
		input logic          bitv,
		input logic [IW-1:0] p
	);
		logic [IW:0]   t;
		logic [IW-1:0] u;
		logic [IW:0]   s;
		t = {r, 1'b0};
		u = (t >= {1'b0, p}) ? IW'(t - {1'b0, p}) : t[IW-1:0];
		s = {1'b0, u} + (bitv ? {1'b0, addend} : {(IW+1){1'b0}});
		mstep = (s >= {1'b0, p}) ? IW'(s - {1'b0, p}) : s[IW-1:0];
	endfunction

	logic [BASE_W-1:0] a_q;
	logic [EXP_W-1:0]  b_q;
	logic [MW-1:0]     n_q;
	logic [MW-1:0]     n_sat;
	logic [RW-1:0]     prev_q, cur_q;
	logic [IW-1:0]     fidx_q;
	logic [IW-1:0]     period_q;
	logic [IW-1:0]     x_q, acc_q, ysh_q, r1_q, r2_q;
	logic [CW-1:0]     mc_q;
	logic [BW-1:0]     cnt_q;
	logic              out_valid_q;
	logic [RES_W-1:0]  res_q;

	logic [MW-1:0]     fsum;
	logic [RW-1:0]     fnext;
	logic [RW-1:0]     wdata;
	logic              fmatch, flast, fdone;
	logic [IW:0]       at;
	logic [IW-1:0]     amod;
	logic [IW-1:0]     r1n, r2n;
	logic              mc_last, cnt_last;
	logic [RW-1:0]     rdata;

	// Clamp the modulus to the supported range
	assign n_sat = (modulus_value > MOD_W'(MAX_MODULUS)) ? MW'(MAX_MODULUS)
		: modulus_value[MW-1:0];

	// Fibonacci step mod n
	assign fsum  = {1'b0, prev_q} + {1'b0, cur_q};
	assign fnext = (fsum >= n_q) ? RW'(fsum - n_q) : fsum[RW-1:0];
	always_comb begin
		if (fidx_q == '0) begin
			wdata = '0;
		end else if (fidx_q == IW'(1)) begin
			wdata = RW'(1);
		end else begin
			wdata = fnext;
		end
	end
	assign fmatch = (fidx_q >= IW'(2)) && (cur_q == '0) && (fnext == RW'(1));
	assign flast  = fidx_q == IW'(TABLE_DEPTH - 1);
	assign fdone  = (fidx_q >= IW'(2)) && (fmatch || flast);

	// One bit of a mod p, restoring
	assign at   = {x_q, a_q[BASE_W-1]};
	assign amod = (at >= {1'b0, period_q}) ? IW'(at - {1'b0, period_q}) : at[IW-1:0];

	// Two multiply lanes sharing the multiplier bits of x
	assign r1n = mstep(r1_q, acc_q, ysh_q[IW-1], period_q);
	assign r2n = mstep(r2_q, x_q, ysh_q[IW-1], period_q);

	assign mc_last  = mc_q == CW'(IW - 1);
	assign cnt_last = cnt_q == BW'(BASE_W - 1);

	assign sts.small_mod = n_q <= MW'(1);
	assign sts.fill_done = fdone;
	assign sts.amod_done = cnt_last;
	assign sts.pow_done  = mc_last && cnt_last;
	assign sts.out_free  = !out_valid_q || !out_stall;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fill_step && fdone) begin
				period_q <= fmatch ? fidx_q - IW'(1) : IW'(TABLE_DEPTH - 1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q    <= base_value;
			b_q    <= exponent_value;
			n_q    <= n_sat;
			fidx_q <= '0;
			prev_q <= '0;
			cur_q  <= RW'(1);
			cnt_q  <= '0;
			x_q    <= '0;
		end
		if (cmd.fill_step) begin
			fidx_q <= fidx_q + IW'(1);
			if (fidx_q >= IW'(2)) begin
				prev_q <= cur_q;
				cur_q  <= fnext;
			end
		end
		if (cmd.amod_step) begin
			x_q   <= amod;
			a_q   <= a_q << 1;
			cnt_q <= cnt_q + BW'(1);
		end
		if (cmd.pow_init) begin
			acc_q <= IW'(1);
			ysh_q <= x_q;
			r1_q  <= '0;
			r2_q  <= '0;
			mc_q  <= '0;
			cnt_q <= '0;
		end
		if (cmd.mul_step) begin
			if (mc_last) begin
				if (b_q[0]) begin
					acc_q <= r1n;
				end
				x_q   <= r2n;
				ysh_q <= r2n;
				r1_q  <= '0;
				r2_q  <= '0;
				mc_q  <= '0;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q + BW'(1);
			end else begin
				r1_q  <= r1n;
				r2_q  <= r2n;
				ysh_q <= ysh_q << 1;
				mc_q  <= mc_q + CW'(1);
			end
		end
		if (cmd.out_load) begin
			res_q <= (n_q <= MW'(1)) ? '0 : RES_W'(rdata);
		end
	end

	fopm_ram #(
		.WIDTH (RW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (cmd.fill_step),
		.waddr (fidx_q),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (acc_q),
		.rdata (rdata)
	);

	assign out_valid   = out_valid_q;
	assign fib_residue = res_q;

endmodule

@@ tb/fibonacci_of_power_mod_core_tb.sv @@
module fibonacci_of_power_mod_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fopm_pkg::*;

	localparam int MAX_MOD    = MAX_MODULUS_DEF;
	localparam int TBL_DEPTH  = TABLE_DEPTH_DEF;
	localparam int WDOG_LIMIT = 60000;
	localparam int N_RANDOM   = 100;
	localparam int N_DIRECTED = 14;

	typedef struct {
		logic [BASE_W-1:0] a;
		logic [EXP_W-1:0]  b;
		logic [MOD_W-1:0]  n;
		bit                known;
		logic [RES_W-1:0]  res;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [BASE_W-1:0]  base_value;
	logic [EXP_W-1:0]   exponent_value;
	logic [MOD_W-1:0]   modulus_value;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [RES_W-1:0]   fib_residue;

	logic [RES_W-1:0] pending_residues[$];
	int errors = 0;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles = 0;

	fibonacci_of_power_mod_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.base_value(base_value),
		.exponent_value(exponent_value),
		.modulus_value(modulus_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fib_residue(fib_residue)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Fibonacci(a^b) mod n, with the period found by filling a residue table
	function automatic logic [RES_W-1:0] fib_of_power(logic [BASE_W-1:0] a,
			logic [EXP_W-1:0] b, logic [MOD_W-1:0] n_in);
		int n;
		int p;
		int fib[TBL_DEPTH];
		logic [63:0] x;
		logic [63:0] e;
		logic [63:0] acc;
		n = n_in;
		p = 0;
		if (n > MAX_MOD)
			n = MAX_MOD;
		if (n <= 1)
			return '0;
		fib[0] = 0;
		fib[1] = 1;
		for (int i = 2; i < TBL_DEPTH; i++) begin
			fib[i] = (fib[i-1] + fib[i-2]) % n;
			if (fib[i-1] == 0 && fib[i] == 1) begin
				p = i - 1;
				break;
			end
		end
		if (p == 0)
			p = TBL_DEPTH - 1;
		x = a % p;
		e = b;
		acc = 1;
		while (e != 0) begin
			if (e[0])
				acc = (acc * x) % p;
			x = (x * x) % p;
			e = e >> 1;
		end
		if (acc >= TBL_DEPTH)
			acc = 0;
		return fib[acc][RES_W-1:0];
	endfunction

	// Offer one word, hold it until accepted, then queue its expected residue
	task automatic send_word(stim_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		base_value     <= row.a;
		exponent_value <= row.b;
		modulus_value  <= row.n;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (row.known)
			pending_residues = {pending_residues, row.res};
		else
			pending_residues = {pending_residues, fib_of_power(row.a, row.b, row.n)};
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [MOD_W-1:0] rand_modulus();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return MOD_W'($urandom_range(1));
		else if (r < 75)
			return MOD_W'($urandom_range(40, 2));
		else if (r < 92)
			return MOD_W'($urandom_range(300, 41));
		else
			return MOD_W'($urandom_range(2047, 301));
	endfunction

	// Check result words and stall the output; watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_residues.size() == 0) begin
					$error("fib_residue: unexpected word, actual %0d", fib_residue);
					errors++;
				end else begin
					if (fib_residue !== pending_residues[0]) begin
						$error("fib_residue: expected %0d, actual %0d",
							pending_residues[0], fib_residue);
						errors++;
					end
					void'(pending_residues.pop_front());
				end
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("[fibonacci_of_power_mod_core] ERROR");
				$finish;
			end
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	initial begin
		stim_row_t directed[N_DIRECTED];
		stim_row_t row;
		in_valid       = 1'b0;
		base_value     = '0;
		exponent_value = '0;
		modulus_value  = '0;
		send_idle_pct  = 19;
		recv_idle_pct  = 48;
		arst_n         = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words: extremes, modulus zero/one, exponent zero, saturation
		directed = '{
			'{64'd5, 64'd3, 11'd1, 1'b1, 10'd0},
			'{'1, '1, 11'd0, 1'b1, 10'd0},
			'{64'd7, 64'd0, 11'd2, 1'b1, 10'd1},
			'{'1, 64'd0, 11'd1024, 1'b1, 10'd1},
			'{64'd0, 64'd0, 11'd2047, 1'b1, 10'd1},
			'{64'd0, 64'd5, 11'd10, 1'b1, 10'd0},
			'{'1, '1, 11'd1024, 1'b0, '0},
			'{'1, '1, 11'd2047, 1'b0, '0},
			'{'1, '1, 11'd2, 1'b0, '0},
			'{64'd2, 64'd10, 11'd1000, 1'b0, '0},
			'{64'd3, 64'd2, 11'd13, 1'b0, '0},
			'{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 11'd1023,
				1'b0, '0},
			'{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 11'd1025,
				1'b0, '0},
			'{64'd1, '1, 11'd3, 1'b0, '0}
		};
		foreach (directed[i])
			send_word(directed[i]);

		// Hold off until every directed result is back
		in_valid <= 1'b0;
		while (pending_residues.size() != 0)
			@(posedge clk);

		// Random words across three idling phases
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				send_idle_pct = 48;
				recv_idle_pct = 19;
			end else if (i == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			row.known = 1'b0;
			row.res   = '0;
			row.n     = rand_modulus();
			row.a     = ($urandom_range(3) == 0) ? 64'($urandom_range(20)) : rand64();
			row.b     = ($urandom_range(4) == 0) ? 64'($urandom_range(3)) : rand64();
			send_word(row);
		end
		in_valid <= 1'b0;

		// Drain and let the block settle
		while (pending_residues.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("[fibonacci_of_power_mod_core] OK");
		else
			$display("[fibonacci_of_power_mod_core] ERROR");
		$finish;
	end

endmodule
